FILE: design/pvacc_pkg.sv
// Shared types, constants and field helpers for the POLYVAL accumulator.
`timescale 1ns / 1ps

package pvacc_pkg;

   // Field element and block geometry
   localparam int ELEM_W      = 128;
   localparam int HALF_W      = 64;
   localparam int BLOCK_BYTES = 16;
   localparam int COUNT_W     = 5;
   localparam int DIGIT_W     = 8;
   localparam int DIGIT_COUNT = ELEM_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(DIGIT_COUNT);

   // Stream word widths
   localparam int REQ_DATA_W = 136;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 128;

   // Register file geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // Command codes carried in tuser
   localparam logic [REQ_USER_W-1:0] CMD_ABSORB = 2'd0;
   localparam logic [REQ_USER_W-1:0] CMD_FINISH = 2'd1;
   localparam logic [REQ_USER_W-1:0] CMD_CLEAR  = 2'd2;

   // Register index codes (address bit 3)
   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   // Reflected reduction tail: (P >> 1) for P = x^128+x^127+x^126+x^121+1
   localparam logic [ELEM_W-1:0] RED_TAIL = {8'hE1, 120'd0};

   typedef logic [ELEM_W-1:0] elem_type;

   // Start request from the sequencer to the multiplier
   typedef struct packed {
      logic start;
   } mul_ctl_type;

   // Multiplier status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

   // Multiply by x^-1 modulo the field polynomial
   function automatic elem_type mul_xinv(input elem_type v);
      mul_xinv = (v >> 1) ^ (v[0] ? RED_TAIL : '0);
   endfunction

   // Keep the first n bytes of a little-endian block, zero the rest
   function automatic elem_type pad_block(input elem_type v,
                                          input logic [COUNT_W-1:0] n);
      elem_type mask;
      mask = '0;
      for (int k = 0; k < BLOCK_BYTES; k++) begin
         mask[k*8 +: 8] = (COUNT_W'(k) < n) ? 8'hFF : 8'h00;
      end
      pad_block = v & mask;
   endfunction

endpackage

FILE: design/pvacc_csr.sv
// Key register file behind the APB-style configuration port.
`timescale 1ns / 1ps

module pvacc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pvacc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pvacc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pvacc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   output pvacc_pkg::elem_type                key
);

   logic [pvacc_pkg::HALF_W-1:0] key_low_ff;
   logic [pvacc_pkg::HALF_W-1:0] key_high_ff;
   logic                         wr_en;
   logic                         reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Write a key half on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (wr_en) begin
         case (reg_sel)
            pvacc_pkg::REG_KEY_LOW:  key_low_ff  <= csr_pwdata;
            pvacc_pkg::REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Read back the selected half
   always_comb begin
      case (reg_sel)
         pvacc_pkg::REG_KEY_LOW:  csr_prdata = key_low_ff;
         pvacc_pkg::REG_KEY_HIGH: csr_prdata = key_high_ff;
         default:                 csr_prdata = '0;
      endcase
   end

   assign key = {key_high_ff, key_low_ff};

endmodule

FILE: design/pvacc_gfmul.sv
// Digit-serial GF(2^128) multiplier: product = a * b * x^-128, 8 bits per cycle.
`timescale 1ns / 1ps

module pvacc_gfmul (
   input  logic                  clock,
   input  logic                  reset,
   input  pvacc_pkg::mul_ctl_type ctl,
   input  pvacc_pkg::elem_type   op_a,
   input  pvacc_pkg::elem_type   op_b,
   output pvacc_pkg::mul_sts_type sts,
   output pvacc_pkg::elem_type   product
);

   pvacc_pkg::elem_type                   a_ff;
   pvacc_pkg::elem_type                   a_in;
   pvacc_pkg::elem_type                   p_ff;
   pvacc_pkg::elem_type                   p_in;
   logic [pvacc_pkg::DIGIT_CNT_W-1:0]     cnt_ff;
   logic                                  busy_ff;
   logic                                  done_ff;
   logic                                  last_digit;

   assign last_digit = busy_ff && (cnt_ff == pvacc_pkg::DIGIT_CNT_W'(pvacc_pkg::DIGIT_COUNT - 1));

   // Fold one digit of a into the partial product, dividing by x each bit
   always_comb begin
      pvacc_pkg::elem_type acc;
      acc = p_ff;
      for (int j = 0; j < pvacc_pkg::DIGIT_W; j++) begin
         if (a_ff[j]) begin
            acc = acc ^ op_b;
         end
         acc = pvacc_pkg::mul_xinv(acc);
      end
      p_in = acc;
      a_in = a_ff >> pvacc_pkg::DIGIT_W;
   end

   // Sequence the digits; load on start, flag done after the last digit
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= last_digit;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + pvacc_pkg::DIGIT_CNT_W'(1);
            if (last_digit) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Operand and partial product registers
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff <= op_a;
         p_ff <= '0;
      end else if (busy_ff) begin
         a_ff <= a_in;
         p_ff <= p_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = p_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff && !done_ff)
      else $error("multiplier started while a product is in flight");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      last_digit |=> done_ff && !busy_ff)
      else $error("multiplier did not finish after its last digit");

   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0)
      else $error("digit counter not parked at zero while idle");

endmodule

FILE: design/polyval_accumulator_unit.sv
// Top level: POLYVAL accumulator with command sequencer and tag output register.
//
//   channel  | direction | handshake               | word
//   req      | in        | req_tvalid/req_tready   | tdata: data_low, data_high, valid_bytes;
//            |           |                         | tuser: cmd
//   rsp      | out       | rsp_tvalid/rsp_tready   | tdata: tag_low, tag_high
//   csr      | in/out    | psel+penable, pready=1  | 64-bit key_low @0x0, key_high @0x8
//
// An absorb word with a nonzero count occupies the multiplier from acceptance until the
// next word can be taken: a load, 16 eight-bit digits, then a writeback.
// Finish, clear, empty absorb and unused commands leave the sequencer idle.
// A finish word is taken while the tag register is empty or being drained that cycle.
// Reset is synchronous and clears the accumulator, both key halves and the tag valid flag.
// A stalled tag holds in its register; absorb and clear words still go through meanwhile.
`timescale 1ns / 1ps

module polyval_accumulator_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [63:0] data_low, [127:64] data_high, [132:128] valid_bytes, [135:133] zero
   input  logic [pvacc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] cmd
   input  logic [pvacc_pkg::REQ_USER_W-1:0]    req_tuser,
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [63:0] tag_low, [127:64] tag_high
   output logic [pvacc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pvacc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pvacc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pvacc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic {
      ST_IDLE,
      ST_MUL
   } state_type;

   state_type                             state_ff;
   pvacc_pkg::elem_type                   acc_ff;
   logic                                  rsp_valid_ff;
   logic [pvacc_pkg::RSP_DATA_W-1:0]      rsp_data_ff;

   pvacc_pkg::elem_type                   key;
   pvacc_pkg::elem_type                   blk;
   pvacc_pkg::elem_type                   blk_pad;
   pvacc_pkg::elem_type                   product;
   logic [pvacc_pkg::COUNT_W-1:0]         valid_bytes;
   logic [pvacc_pkg::REQ_USER_W-1:0]      cmd;
   logic                                  out_free;
   logic                                  accept;
   pvacc_pkg::mul_ctl_type                mul_ctl;
   pvacc_pkg::mul_sts_type                mul_sts;

   // Unpack the request word
   assign blk         = req_tdata[pvacc_pkg::ELEM_W-1:0];
   assign valid_bytes = req_tdata[pvacc_pkg::ELEM_W +: pvacc_pkg::COUNT_W];
   assign cmd         = req_tuser;
   assign blk_pad     = pvacc_pkg::pad_block(blk, valid_bytes);

   // Take a word when idle; a finish also needs room in the tag register
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && ((cmd != pvacc_pkg::CMD_FINISH) || out_free);
   assign accept     = req_tvalid && req_tready;

   assign mul_ctl.start = accept && (cmd == pvacc_pkg::CMD_ABSORB) && (valid_bytes != '0);

   pvacc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key         (key)
   );

   pvacc_gfmul u_gfmul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .op_a    (acc_ff ^ blk_pad),
      .op_b    (key),
      .sts     (mul_sts),
      .product (product)
   );

   // Sequencer: dispatch commands, write back the product, drive the tag register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the tag once taken, unless a new finish refills it this cycle
         if (rsp_valid_ff && rsp_tready && !(accept && (cmd == pvacc_pkg::CMD_FINISH))) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (cmd)
                     pvacc_pkg::CMD_ABSORB: begin
                        if (mul_ctl.start) begin
                           state_ff <= ST_MUL;
                        end
                     end
                     pvacc_pkg::CMD_FINISH: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff  <= blk_pad ^ acc_ff;
                     end
                     pvacc_pkg::CMD_CLEAR: begin
                        acc_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_MUL: begin
               if (mul_sts.done) begin
                  acc_ff   <= product;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> state_ff == ST_MUL)
      else $error("product arrived outside a multiply");

   a_mul_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> !req_tready && (mul_sts.busy || mul_sts.done))
      else $error("sequencer waits on an idle multiplier or takes input mid-multiply");

   a_tag_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled tag word changed or dropped");

endmodule

FILE: test/polyval_accumulator_checker.sv
// Checker for the POLYVAL accumulator: tracks the key, predicts tags and compares them.
`timescale 1ns / 1ps

module polyval_accumulator_checker
   import pvacc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   // [63:0] data_low, [127:64] data_high, [132:128] valid_bytes, [135:133] zero
   input  logic [REQ_DATA_W-1:0]    req_tdata,
   // [1:0] cmd
   input  logic [REQ_USER_W-1:0]    req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [63:0] tag_low, [127:64] tag_high
   input  logic [RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   input  logic                     csr_pready,
   output logic [31:0]              fail_count,
   output logic [31:0]              tags_pending
);

   // Low half of the reduction polynomial, bit-reflected
   localparam logic [63:0] FOLD_POLY = 64'hC200000000000000;

   logic [127:0] hash_key   = '0;
   logic [127:0] hash_state = '0;
   logic [127:0] tag_queue[$];
   int           mismatches = 0;

   assign fail_count   = mismatches;
   assign tags_pending = tag_queue.size();

   // Carry-less 64 x 64 product
   function automatic logic [127:0] clmul_64(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = '0;
      for (int i = 0; i < 64; i++) begin
         if (b[i]) prod ^= {64'd0, a} << i;
      end
      return prod;
   endfunction

   // Multiply by x^-64 modulo the field polynomial
   function automatic logic [127:0] fold_x64(input logic [127:0] p);
      logic [127:0] r;
      r = clmul_64(p[63:0], FOLD_POLY);
      return {p[63:0] ^ r[127:64], p[127:64] ^ r[63:0]};
   endfunction

   // a * b * x^-128 in GF(2^128)
   function automatic logic [127:0] polyval_dot(input logic [127:0] a, input logic [127:0] b);
      logic [127:0] c0, c2, mid, q, r;
      c0  = clmul_64(a[63:0], b[63:0]);
      c2  = clmul_64(a[127:64], b[127:64]);
      mid = clmul_64(a[63:0], b[127:64]) ^ clmul_64(a[127:64], b[63:0]);
      q   = {c0[127:64] ^ mid[63:0], c0[63:0]};
      r   = {c2[127:64], c2[63:0] ^ mid[127:64]};
      q   = fold_x64(fold_x64(q));
      return r ^ q;
   endfunction

   // Zero every byte past the valid count; counts above 16 keep the whole block
   function automatic logic [127:0] trim_block(input logic [127:0] v, input logic [4:0] n);
      logic [127:0] t;
      t = v;
      for (int k = 0; k < BLOCK_BYTES; k++) begin
         if (k >= n) t[k*8 +: 8] = 8'h00;
      end
      return t;
   endfunction

   always @(posedge clock) begin
      logic [127:0] want;
      logic [127:0] block;
      if (reset) begin
         hash_key   = '0;
         hash_state = '0;
         tag_queue.delete();
      end else begin
         // Track key writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[3] == REG_KEY_HIGH) hash_key[127:64] = csr_pwdata;
            else hash_key[63:0] = csr_pwdata;
         end

         // Compare each tag word against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (tag_queue.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected tag word %h", $time, rsp_tdata);
            end else begin
               want = tag_queue.pop_front();
               if (rsp_tdata[63:0] !== want[63:0]) begin
                  mismatches++;
                  $display("%0t: tag_low expected %h actual %h",
                           $time, want[63:0], rsp_tdata[63:0]);
               end
               if (rsp_tdata[127:64] !== want[127:64]) begin
                  mismatches++;
                  $display("%0t: tag_high expected %h actual %h",
                           $time, want[127:64], rsp_tdata[127:64]);
               end
            end
         end

         // Advance the accumulator on each accepted request word
         if (req_tvalid && req_tready) begin
            block = trim_block(req_tdata[127:0], req_tdata[132:128]);
            case (req_tuser)
               CMD_ABSORB: begin
                  if (req_tdata[132:128] != 5'd0)
                     hash_state = polyval_dot(hash_state ^ block, hash_key);
               end
               CMD_FINISH: tag_queue.push_back(block ^ hash_state);
               CMD_CLEAR:  hash_state = '0;
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: test/polyval_accumulator_unit_test.sv
// Top of the POLYVAL accumulator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module polyval_accumulator_unit_test;
   import pvacc_pkg::*;

   localparam logic [REQ_USER_W-1:0] CMD_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int QUIET_CYCLES = 24;
   localparam int WORDS_PER_PHASE = 110;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic [31:0]           fail_count;
   logic [31:0]           tags_pending;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int words_sent = 0;

   polyval_accumulator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   polyval_accumulator_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .tags_pending(tags_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Stall the tag channel at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // End the run when nothing moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("polyval_accumulator_unit verification failed");
      $finish;
   end

   // Mostly random halves, sometimes all zeros or all ones
   function automatic logic [63:0] random_half();
      case ($urandom_range(7))
         0: return 64'd0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Setup and access phase of one register write
   task automatic csr_write(input logic index, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offer one request word and hold it until accepted
   task automatic send_word(input logic [REQ_USER_W-1:0] cmd, input logic [63:0] dlo,
                            input logic [63:0] dhi, input logic [4:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, count, dhi, dlo};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      if (cmd != CMD_UNUSED) words_sent++;
   endtask

   // Hold off the sender until every tag has drained, then let the core settle
   task automatic drain_tags();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (tags_pending != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // One hashed message: optional clear, a few blocks, a finish; now and then noise
   task automatic hash_message();
      int blocks;
      logic [4:0] count;
      if ($urandom_range(7) == 0)
         send_word(2'($urandom_range(3)), random_half(), random_half(),
                   5'($urandom_range(31)));
      if ($urandom_range(3) != 0) send_word(CMD_CLEAR, random_half(), random_half(), 5'd16);
      blocks = $urandom_range(6);
      for (int b = 0; b < blocks; b++) begin
         count = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd16;
         send_word(CMD_ABSORB, random_half(), random_half(), count);
      end
      count = ($urandom_range(1) == 0) ? 5'($urandom_range(31)) : 5'd16;
      send_word(CMD_FINISH, random_half(), random_half(), count);
   endtask

   initial begin
      logic [63:0] key_lo, key_hi;
      int target;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Tag straight out of reset, zero key and zero accumulator
      send_word(CMD_FINISH, '1, '1, 5'd16);
      drain_tags();

      csr_write(REG_KEY_LOW, 64'h0123456789ABCDEF);
      csr_write(REG_KEY_HIGH, 64'hFEDCBA9876543210);

      // Directed: count boundaries, empty absorb, oversized counts, unused command
      send_word(CMD_FINISH, 64'h0, 64'h0, 5'd0);
      send_word(CMD_ABSORB, '1, '1, 5'd16);
      send_word(CMD_FINISH, 64'h0, 64'h0, 5'd16);
      send_word(CMD_ABSORB, '1, '1, 5'd0);
      send_word(CMD_FINISH, '1, '1, 5'd0);
      send_word(CMD_ABSORB, '1, '1, 5'd1);
      send_word(CMD_ABSORB, '1, '1, 5'd7);
      send_word(CMD_ABSORB, '1, '1, 5'd8);
      send_word(CMD_ABSORB, '1, '1, 5'd9);
      send_word(CMD_ABSORB, '1, '1, 5'd15);
      send_word(CMD_FINISH, '1, '1, 5'd8);
      send_word(CMD_ABSORB, 64'h8000000000000001, 64'h8000000000000001, 5'd17);
      send_word(CMD_ABSORB, random_half(), random_half(), 5'd31);
      send_word(CMD_FINISH, '1, '1, 5'd31);
      send_word(CMD_UNUSED, '1, '1, 5'd16);
      send_word(CMD_FINISH, '1, '1, 5'd9);
      send_word(CMD_CLEAR, '1, '1, 5'd31);
      send_word(CMD_FINISH, 64'h0, 64'h0, 5'd16);
      send_word(CMD_ABSORB, 64'h0, 64'h0, 5'd16);
      send_word(CMD_FINISH, '1, 64'h0, 5'd15);
      send_word(CMD_FINISH, 64'h0, '1, 5'd1);

      // Random phases, each setting a key and an idle and stall pattern (phases 0 and 4 share one)
      for (int phase = 0; phase < 5; phase++) begin
         drain_tags();
         case (phase)
            0: begin key_lo = '0; key_hi = '0; end
            1: begin key_lo = '1; key_hi = '1; end
            3: begin key_lo = 64'd1; key_hi = 64'd0; end
            default: begin key_lo = {$urandom, $urandom}; key_hi = {$urandom, $urandom}; end
         endcase
         csr_write(REG_KEY_LOW, key_lo);
         csr_write(REG_KEY_HIGH, key_hi);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 58; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 58; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         target = words_sent + WORDS_PER_PHASE;
         while (words_sent < target) hash_message();
      end

      drain_tags();
      if (fail_count == 0 && tags_pending == 0)
         $display("polyval_accumulator_unit verification clean");
      else
         $display("polyval_accumulator_unit verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
design/pvacc_pkg.sv
design/pvacc_csr.sv
design/pvacc_gfmul.sv
design/polyval_accumulator_unit.sv
test/polyval_accumulator_checker.sv
test/polyval_accumulator_unit_test.sv
